[src/bip39_pkg.sv]
// Package for the BIP-39 word index generator: SHA-256 constants and helpers.
// Used by bip39_sha_core and bip39_mnemonic_index_generator_core.
package bip39_pkg;

    localparam int unsigned MAX_ENTROPY_BYTES = 32;
    localparam int unsigned MAX_WORDS         = 24;
    localparam logic [2:0]  SIZE_CODE_TOP     = 3'd4;

    typedef logic [31:0] t_word;

    localparam t_word ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam t_word INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // words for size codes 0 to 4: 12, 15, 18, 21, 24
    function automatic logic [4:0] word_count(input logic [2:0] code);
        word_count = 5'(5'd12 + 5'(code) * 5'd3);
    endfunction

endpackage

[src/bip39_mnemonic_index_generator_core.sv]
// BIP-39 entropy to mnemonic word indices: top level.
// Depends on bip39_pkg and bip39_sha_core.
//
// channel   | valid          | stall          | payload
// entropy   | i_in_valid     | o_in_stall     | i_entropy_byte
// words     | o_out_valid    | i_out_stall    | o_word_index, o_word_position, o_last_word
// config    | i_cfg_wr_en    | -              | i_cfg_wr_data
//
// Bytes load one per cycle while the input is not stalled. After the last byte
// come a start pulse, the SHA-256 rounds in bip39_sha_core, a finish state and
// a checksum load; then one word is emitted per cycle while the output is not stalled.
// Input is stalled from the last byte until the final word is taken.
// Reset is synchronous, active low; it clears the size code, byte count and sequencer.
module bip39_mnemonic_index_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_entropy_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_word_index,
    output logic [4:0]  o_word_position,
    output logic        o_last_word
);

    typedef enum logic [1:0] {S_LOAD, S_HASH, S_EMIT} t_state;

    t_state       r_state;
    logic [2:0]   r_code;
    logic [7:0]   r_store [32];
    logic [5:0]   r_loaded;
    logic [7:0]   r_csum;
    logic [4:0]   r_emit;
    logic [8:0]   r_bit;
    logic         r_start;
    logic         r_out_valid;
    logic [10:0]  r_word;
    logic [4:0]   r_pos;
    logic         r_last;

    logic [5:0]   n_bytes;
    logic [4:0]   n_words;
    logic [8:0]   n_ebits;
    logic         in_acc, out_acc, sha_done;
    bip39_pkg::t_word blk [16];
    bip39_pkg::t_word digest0;
    logic [10:0]  n_word;

    always_comb begin
        logic [2:0] c;
        c       = (r_code > bip39_pkg::SIZE_CODE_TOP) ? bip39_pkg::SIZE_CODE_TOP : r_code;
        n_bytes = 6'(6'd16 + {1'b0, c, 2'b00});
        n_words = bip39_pkg::word_count(c);
        n_ebits = {n_bytes, 3'b000};
    end

    // padded block built from the stored bytes
    always_comb begin
        logic [7:0] b;
        for (int i = 0; i < 64; i++) begin
            if (6'(i) < n_bytes)       b = r_store[i[4:0]];
            else if (6'(i) == n_bytes) b = bip39_pkg::PAD_BYTE;
            else if (i == 62)          b = {7'd0, n_ebits[8]};
            else if (i == 63)          b = n_ebits[7:0];
            else                       b = 8'd0;
            blk[i/4][31 - 8*(i%4) -: 8] = b;
        end
    end

    // 11 bits MSB-first from entropy || checksum
    always_comb begin
        logic [8:0] p;
        logic [7:0] by;
        for (int k = 0; k < 11; k++) begin
            p = 9'(r_bit + 9'(k));
            if (p < n_ebits)                 by = r_store[p[7:3]];
            else if ((p - n_ebits) < 9'd8)   by = r_csum;
            else                             by = 8'd0;
            n_word[10-k] = by[3'd7 - p[2:0]];
        end
    end

    bip39_sha_core u_sha (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_block   (blk),
        .o_done    (sha_done),
        .o_digest0 (digest0)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (in_acc) r_store[r_loaded[4:0]] <= i_entropy_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_code      <= '0;
            r_loaded    <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_emit      <= '0;
            r_bit       <= '0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_wr_en) begin
                r_code   <= i_cfg_wr_data;
                r_loaded <= '0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_loaded + 6'd1 >= n_bytes) begin
                            r_loaded <= '0;
                            r_start  <= 1'b1;
                            r_state  <= S_HASH;
                        end else begin
                            r_loaded <= r_loaded + 6'd1;
                        end
                    end
                end
                S_HASH: begin
                    if (sha_done) begin
                        r_csum  <= digest0[31:24];
                        r_emit  <= '0;
                        r_bit   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || out_acc) begin
                        if (r_emit == n_words) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_LOAD;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_word      <= n_word;
                            r_pos       <= r_emit;
                            r_last      <= (r_emit + 5'd1 == n_words);
                            r_emit      <= r_emit + 5'd1;
                            r_bit       <= r_bit + 9'd11;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_LOAD);
    assign o_out_valid     = r_out_valid;
    assign o_word_index    = r_word;
    assign o_word_position = r_pos;
    assign o_last_word     = r_last;

    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall) else $error("input open while emitting");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_pos < n_words) else $error("position range");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_last) |=> !r_out_valid) else $error("word after last");

endmodule

[src/bip39_sha_core.sv]
// Single-block SHA-256 compression, one round per cycle.
// Depends on bip39_pkg. Takes the 16 padded message words, returns the first digest word.
module bip39_sha_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  bip39_pkg::t_word     i_block [16],
    output logic                 o_done,
    output bip39_pkg::t_word     o_digest0
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state            r_state;
    logic [5:0]        r_round;
    bip39_pkg::t_word  r_w [16];
    bip39_pkg::t_word  r_v [8];
    bip39_pkg::t_word  r_digest0;
    logic              r_done;

    bip39_pkg::t_word n_wnew, w, s0, s1, ch, maj, t1, t2, a15, a2, e0;

    always_comb begin
        a15    = r_w[1];
        a2     = r_w[14];
        s0     = bip39_pkg::rotr(a15, 7) ^ bip39_pkg::rotr(a15, 18) ^ (a15 >> 3);
        s1     = bip39_pkg::rotr(a2, 17) ^ bip39_pkg::rotr(a2, 19) ^ (a2 >> 10);
        n_wnew = r_w[0] + s0 + r_w[9] + s1;
        w      = r_w[0];
        e0     = r_v[4];
        t1 = r_v[7] + (bip39_pkg::rotr(e0, 6) ^ bip39_pkg::rotr(e0, 11) ^ bip39_pkg::rotr(e0, 25))
           + ((e0 & r_v[5]) ^ (~e0 & r_v[6])) + bip39_pkg::ROUND_K[r_round] + w;
        ch  = bip39_pkg::rotr(r_v[0], 2) ^ bip39_pkg::rotr(r_v[0], 13)
            ^ bip39_pkg::rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = ch + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 16; i++) r_w[i] <= i_block[i];
                        for (int i = 0; i < 8; i++) r_v[i] <= bip39_pkg::INIT_H[i];
                        r_round <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    // shift window: r_w[0] is the current word
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= n_wnew;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_digest0 <= r_v[0] + bip39_pkg::INIT_H[0];
                    r_done    <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_digest0 = r_digest0;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_round == 6'd63) |=> r_state == S_FIN)
        else $error("round count");

endmodule
